// ----- src/rgbfb_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbfb_pkg
// shared types, codes and constants of the rgb565 alpha blend frame buffer
// ----------------------------------------------------------------------------
package rgbfb_pkg;

    localparam int FB_WIDTH  = 320;
    localparam int FB_HEIGHT = 240;

    localparam logic [31:0] RB_G_MASK    = 32'h07E0_F81F;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [15:0] PIX_INIT     = 16'hFFFF;
    localparam logic [15:0] PIX_ZERO     = 16'h0000;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] STAT_BLEND   = 3'd0;
    localparam logic [2:0] STAT_OPAQUE  = 3'd1;
    localparam logic [2:0] STAT_SKIP    = 3'd2;
    localparam logic [2:0] STAT_RANGE   = 3'd3;
    localparam logic [2:0] STAT_READ    = 3'd4;
    localparam logic [2:0] STAT_CLEARED = 3'd5;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [23:0]        color;
    } req_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOKUP,
        S_FINISH,
        S_CLEAR
    } fb_state_t;

endpackage

// ----- src/rgbfb_store.sv -----
// ----------------------------------------------------------------------------
// rgbfb_store
// single port pair pixel memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rgbfb_store #(
    parameter int DEPTH = 76800,
    parameter int AW    = 17
) (
    input  logic                clk,
    input  rgbfb_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [15:0]         wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [15:0]         rd_data
);
    import rgbfb_pkg::*;

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/rgbfb_blend.sv -----
// ----------------------------------------------------------------------------
// rgbfb_blend
// packed green / red-blue blend of one rgb565 pixel with a 6-bit weight
// ----------------------------------------------------------------------------
module rgbfb_blend (
    input  logic [15:0] bg,
    input  logic [15:0] fg,
    input  logic [5:0]  weight,
    output logic [15:0] pixel
);
    import rgbfb_pkg::*;

    logic [31:0] b_spread;
    logic [31:0] f_spread;
    logic [31:0] diff;
    logic [31:0] prod;
    logic [31:0] mix;

    // all arithmetic wraps at 32 bits
    always_comb
    begin
        b_spread = {bg, bg} & RB_G_MASK;
        f_spread = {fg, fg} & RB_G_MASK;
        diff     = f_spread - b_spread;
        prod     = diff * {26'd0, weight};
        mix      = ((prod >> 5) + b_spread) & RB_G_MASK;
        pixel    = mix[31:16] | mix[15:0];
    end

endmodule

// ----- src/rgb565_alpha_blend_framebuffer.sv -----
// ----------------------------------------------------------------------------
// rgb565_alpha_blend_framebuffer
// rgb565 frame buffer with blended draw, read and clear
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready), one word per operation: draw with
// blend, read, or clear. Every request gives exactly one word on rsp
// (valid/ready): the pixel written or read and a status code.
// Draw and read pass through three steps: accept, memory lookup, then write
// back and result load into the output register. The single read port of
// the pixel memory and its registered read set this.
// Clear sweeps the memory one pixel per cycle before its result is loaded.
// After reset the block runs a fill pass that writes 0xFFFF to every pixel;
// req_ready stays low until it is done.
// The result sits in an output register. A new request is accepted while it
// waits; if rsp stays stalled that request holds in its last step, before
// a draw's pixel write, until the register frees up.
// ----------------------------------------------------------------------------
module rgb565_alpha_blend_framebuffer #(
    parameter int WIDTH  = rgbfb_pkg::FB_WIDTH,
    parameter int HEIGHT = rgbfb_pkg::FB_HEIGHT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rgbfb_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rgbfb_pkg::rsp_t rsp
);
    import rgbfb_pkg::*;

    localparam int DEPTH = WIDTH * HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    fb_state_t     state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    req_t          req_reg, req_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_data_reg, out_data_next;

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [15:0]   rd_data;

    logic          in_range;
    logic [31:0]   lin_addr;
    logic [AW-1:0] idx_cur;
    logic          slot_free;
    logic          out_load;
    logic [7:0]    alpha;
    logic [15:0]   fg;
    logic [5:0]    weight;
    logic [15:0]   blend_pix;
    rsp_t          result;
    logic          draw_write;

    assign alpha     = req_reg.color[7:0];
    assign fg        = req_reg.color[23:8];
    assign weight    = 6'((9'({1'b0, alpha}) + 9'd4) >> 3);
    assign slot_free = !out_valid_reg || rsp_ready;

    // sign bit clear and below the limit
    assign in_range = !req_reg.x[15] && ($unsigned(req_reg.x) < 16'(WIDTH))
                   && !req_reg.y[15] && ($unsigned(req_reg.y) < 16'(HEIGHT));
    assign lin_addr = 32'($unsigned(req_reg.y)) * 32'(WIDTH) + 32'($unsigned(req_reg.x));
    assign idx_cur  = AW'(lin_addr);

    rgbfb_blend u_blend (
        .bg     (rd_data),
        .fg     (fg),
        .weight (weight),
        .pixel  (blend_pix)
    );

    rgbfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_cur),
        .rd_data (rd_data)
    );

    // result of the request held in req_reg
    always_comb
    begin
        result.pixel  = PIX_ZERO;
        result.status = STAT_RANGE;
        draw_write    = 1'b0;
        if (req_reg.op == OP_CLEAR)
        begin
            result.status = STAT_CLEARED;
        end
        else if (hit_reg && req_reg.op == OP_READ)
        begin
            result.pixel  = rd_data;
            result.status = STAT_READ;
        end
        else if (hit_reg)
        begin
            if (alpha == ALPHA_CLEAR)
            begin
                result.status = STAT_SKIP;
            end
            else if (alpha == ALPHA_OPAQUE)
            begin
                result.pixel  = fg;
                result.status = STAT_OPAQUE;
                draw_write    = 1'b1;
            end
            else
            begin
                result.pixel  = blend_pix;
                result.status = STAT_BLEND;
                draw_write    = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (req_reg.op == OP_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLEAR:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        req_ready     = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        wr_addr       = cnt_reg;
        wr_data       = PIX_INIT;
        out_load      = 1'b0;
        cnt_next      = cnt_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        case (state_reg)
            S_INIT:
            begin
                mem_ctl.wr_en = 1'b1;
                cnt_next      = cnt_reg + AW'(1);
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                req_next  = req;
            end
            S_LOOKUP:
            begin
                mem_ctl.rd_en = in_range;
                idx_next      = idx_cur;
                hit_next      = in_range && (req_reg.op == OP_DRAW || req_reg.op == OP_READ);
                cnt_next      = '0;
            end
            S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = PIX_ZERO;
                cnt_next      = cnt_reg + AW'(1);
            end
            S_FINISH:
            begin
                out_load      = slot_free;
                mem_ctl.wr_en = slot_free && draw_write;
                wr_addr       = idx_reg;
                wr_data       = result.pixel;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // no read and write of the memory in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("memory read and write overlap");

    // fill pass blocks requests and results
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> (!req_ready && !out_load))
        else $error("request or result during fill pass");

    // a pixel write at finish belongs to an in-range draw
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && state_reg == S_FINISH) |-> (hit_reg && req_reg.op == OP_DRAW))
        else $error("stray pixel write");

    // end of clear sweep leads to a cleared result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && cnt_reg == LAST) |=>
            (state_reg == S_FINISH && result.status == STAT_CLEARED))
        else $error("clear sweep did not finish");

    // a result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp_ready))
        else $error("result overwrote pending word");

endmodule
